// ===== hdl/dvrt_pkg.sv =====
// Shared types, codes and helpers for the distance-vector route table.
`timescale 1ns / 1ps
`default_nettype none

package dvrt_pkg;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // Request kinds
    localparam logic [1:0] ACT_ADV  = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    // Result status codes
    localparam logic [3:0] ST_IGNORED     = 4'd0;
    localparam logic [3:0] ST_ADDED       = 4'd1;
    localparam logic [3:0] ST_UPDATED     = 4'd2;
    localparam logic [3:0] ST_POISONED    = 4'd3;
    localparam logic [3:0] ST_RECONNECTED = 4'd4;
    localparam logic [3:0] ST_UNKNOWN     = 4'd5;
    localparam logic [3:0] ST_FULL        = 4'd6;
    localparam logic [3:0] ST_TICKED      = 4'd7;
    localparam logic [3:0] ST_READ        = 4'd8;

    // Configuration register indexes
    localparam logic [2:0] CFG_IFACE_COUNT = 3'd0;
    localparam logic [2:0] CFG_IFACE_0     = 3'd1;
    localparam logic [2:0] CFG_IFACE_3     = 3'd4;
    localparam logic [2:0] CFG_INF_DIST    = 3'd5;
    localparam logic [2:0] CFG_MAX_DIST    = 3'd6;
    localparam logic [2:0] CFG_TURNS       = 3'd7;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] adv_net;
        logic [5:0]  adv_mask;
        logic [15:0] adv_dist;
        logic [31:0] sender;
        logic [4:0]  read_index;
    } t_request;

    typedef struct packed {
        logic [3:0]  status;
        logic        entry_valid;
        logic        entry_direct;
        logic [31:0] entry_net;
        logic [5:0]  entry_mask;
        logic [15:0] entry_dist;
        logic [31:0] entry_via;
    } t_result;

    // Controller to datapath commands
    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_ACCEPT,
        CMD_EVAL,
        CMD_SCAN,
        CMD_FINISH
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic no_scan;
        logic scan_done;
    } t_dp_status;

    // Network mask for a prefix length; lengths above 32 act as 32
    function automatic logic [31:0] prefix_mask(input logic [5:0] p);
        logic [5:0] q;
        q = (p > 6'd32) ? 6'd32 : p;
        if (p == 6'd0) begin
            return 32'd0;
        end
        return ALL_ONES << (6'd32 - q);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dvrt_ctrl.sv =====
// Sequencing state machine for the route table.
`timescale 1ns / 1ps
`default_nettype none

module dvrt_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire dvrt_pkg::t_dp_status i_status,
    output dvrt_pkg::t_cmd          o_cmd,
    output logic                    o_busy
);
    import dvrt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_FINAL
    } t_state;

    t_state r_state;
    logic   r_busy;

    // Advance state and hold busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_EVAL;
                        r_busy  <= 1'b1;
                    end
                end
                S_EVAL: begin
                    if (i_status.no_scan) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (i_status.scan_done) begin
                        r_state <= S_FINAL;
                    end
                end
                S_FINAL: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    // Decode the command for the datapath
    always_comb begin
        case (r_state)
            S_IDLE:  o_cmd = i_start ? CMD_ACCEPT : CMD_IDLE;
            S_EVAL:  o_cmd = CMD_EVAL;
            S_SCAN:  o_cmd = CMD_SCAN;
            S_FINAL: o_cmd = CMD_FINISH;
            default: o_cmd = CMD_IDLE;
        endcase
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

// ===== hdl/dvrt_datapath.sv =====
// Interface state, route memory, route scan and result register.
`timescale 1ns / 1ps
`default_nettype none

module dvrt_datapath #(
    parameter int NUM_IFACES = 4,
    parameter int MAX_ROUTES = 16,
    parameter int DIST_BITS  = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire dvrt_pkg::t_cmd       i_cmd,
    input  wire dvrt_pkg::t_request   i_request,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [53:0]          i_cfg_data,
    output dvrt_pkg::t_dp_status      o_status,
    output logic                      o_result_valid,
    output dvrt_pkg::t_result         o_result
);
    import dvrt_pkg::*;

    localparam int IW = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;
    localparam int AW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int CW = $clog2(MAX_ROUTES + 1);
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    typedef enum logic [1:0] {
        SM_RECON,
        SM_ADV,
        SM_TICK,
        SM_READ
    } t_scan_mode;

    typedef struct packed {
        logic [31:0]          net;
        logic [5:0]           prefix;
        logic [DIST_BITS-1:0] metric;
        logic [31:0]          hop;
        logic [7:0]           age;
    } t_route;

    // Configuration
    logic [2:0]  r_iface_count;
    logic [53:0] r_iface_reg [NUM_IFACES];
    logic [15:0] r_inf;
    logic [15:0] r_max;
    logic [15:0] r_turns;

    // Interface and route state
    logic [DIST_BITS-1:0] r_iface_dist [NUM_IFACES];
    logic [7:0]           r_iface_age  [NUM_IFACES];
    logic                 r_valid      [MAX_ROUTES];
    t_route               r_mem        [MAX_ROUTES];
    t_route               r_rd_data;

    // Request and scan bookkeeping
    t_request             r_req;
    t_scan_mode           r_mode;
    logic [31:0]          r_key;
    logic [DIST_BITS-1:0] r_sum;
    logic [NUM_IFACES-1:0] r_dead;
    logic [CW-1:0]        r_addr;
    logic                 r_pend;
    logic [AW-1:0]        r_paddr;
    logic                 r_in_range;
    logic                 r_hit;
    logic [AW-1:0]        r_hit_idx;
    t_route               r_hit_rec;
    logic                 r_free_ok;
    logic [AW-1:0]        r_free_idx;
    logic                 r_stb;
    t_result              r_res;

    logic [2:0]           w_used;
    logic [31:0]          w_if_net  [NUM_IFACES];
    logic [31:0]          w_if_mask [NUM_IFACES];
    logic [DIST_BITS-1:0] w_if_start [NUM_IFACES];
    logic                 w_if_inf  [NUM_IFACES];
    logic                 w_snd_hit;
    logic [IW-1:0]        w_snd_idx;
    logic                 w_net_hit;
    logic [IW-1:0]        w_net_idx;
    logic [DIST_BITS-1:0] w_inf_db;
    logic [32:0]          w_sum_full;
    logic [DIST_BITS-1:0] w_sum;
    logic [7:0]           w_inf_turns;
    logic [7:0]           w_stop_turns;
    logic [4:0]           w_route_idx;
    logic                 w_no_scan;
    t_result              w_eval_res;
    t_route               w_tick_rec;
    logic                 w_tick_keep;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    t_route               w_wdata;
    logic [AW-1:0]        w_raddr;
    logic [3:0]           w_fin_status;
    logic                 w_fin_we;
    logic                 w_fin_add;
    t_route               w_fin_rec;
    logic [AW-1:0]        w_fin_addr;
    logic                 w_adv_inf;
    t_result              w_fin_res;

    assign w_inf_turns  = r_turns[7:0];
    assign w_stop_turns = r_turns[15:8];
    assign w_inf_db     = DIST_BITS'(32'(r_inf));
    assign w_used       = (r_iface_count > 3'(NUM_IFACES)) ? 3'(NUM_IFACES) : r_iface_count;
    assign w_route_idx  = 5'(r_req.read_index - 5'(NUM_IFACES));

    // Decode interface registers
    always_comb begin
        for (int g = 0; g < NUM_IFACES; g++) begin
            w_if_mask[g]  = prefix_mask(r_iface_reg[g][37:32]);
            w_if_net[g]   = r_iface_reg[g][31:0] & w_if_mask[g];
            w_if_start[g] = DIST_BITS'(32'(r_iface_reg[g][53:38]));
            w_if_inf[g]   = (32'(r_iface_dist[g]) == 32'(r_inf));
        end
    end

    // Find the interfaces holding the sender and the advertised network
    always_comb begin
        w_snd_hit = 1'b0;
        w_snd_idx = '0;
        w_net_hit = 1'b0;
        w_net_idx = '0;
        for (int g = NUM_IFACES - 1; g >= 0; g--) begin
            if (3'(g) < w_used) begin
                if (w_if_net[g] == (r_req.sender & w_if_mask[g])) begin
                    w_snd_hit = 1'b1;
                    w_snd_idx = IW'(g);
                end
                if (w_if_net[g] == (r_req.adv_net & w_if_mask[g])) begin
                    w_net_hit = 1'b1;
                    w_net_idx = IW'(g);
                end
            end
        end
    end

    // Saturating distance through the sender's interface
    assign w_sum_full = 33'(r_req.adv_dist) + 33'(r_iface_dist[w_snd_idx]);
    assign w_sum      = (w_sum_full > 33'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(w_sum_full);

    // Decide what the first step settles on its own
    always_comb begin
        w_eval_res        = '0;
        w_no_scan         = 1'b0;
        case (r_req.action)
            ACT_ADV: begin
                if (!w_snd_hit) begin
                    w_no_scan         = 1'b1;
                    w_eval_res.status = ST_UNKNOWN;
                end else if (!w_if_inf[w_snd_idx] && w_net_hit && !w_if_inf[w_net_idx]) begin
                    w_no_scan         = 1'b1;
                    w_eval_res.status = ST_IGNORED;
                end
            end
            ACT_TICK: begin
                w_no_scan = 1'b0;
            end
            ACT_READ: begin
                w_eval_res.status = ST_READ;
                if (r_req.read_index < 5'(NUM_IFACES)) begin
                    w_no_scan = 1'b1;
                    w_eval_res.entry_valid  =
                        (r_req.read_index < 5'(w_used)) &&
                        (r_iface_age[r_req.read_index[IW-1:0]] != w_stop_turns);
                    w_eval_res.entry_direct = 1'b1;
                    w_eval_res.entry_net    = w_if_net[r_req.read_index[IW-1:0]];
                    w_eval_res.entry_mask   = r_iface_reg[r_req.read_index[IW-1:0]][37:32];
                    w_eval_res.entry_dist   =
                        16'(32'(r_iface_dist[r_req.read_index[IW-1:0]]));
                end
            end
            default: begin
                w_no_scan         = 1'b1;
                w_eval_res.status = ST_IGNORED;
            end
        endcase
    end

    // Age one route on a tick
    always_comb begin
        logic dead_hit;
        dead_hit   = 1'b0;
        w_tick_rec = r_rd_data;
        for (int g = 0; g < NUM_IFACES; g++) begin
            if (r_dead[g] && ((r_rd_data.hop & w_if_mask[g]) == w_if_net[g])) begin
                dead_hit = 1'b1;
            end
        end
        if (dead_hit) begin
            w_tick_rec.metric = w_inf_db;
            w_tick_rec.age    = 8'd0;
        end
        w_tick_rec.age = w_tick_rec.age + 8'd1;
        w_tick_keep    = 1'b1;
        if (32'(w_tick_rec.metric) == 32'(r_inf)) begin
            if (w_tick_rec.age == w_inf_turns) begin
                w_tick_keep = 1'b0;
            end
        end else if ((32'(w_tick_rec.metric) > 32'(r_max)) ||
                (w_tick_rec.age == w_inf_turns)) begin
            w_tick_rec.metric = w_inf_db;
            w_tick_rec.age    = 8'd0;
        end
    end

    // Settle an advertisement once the scan is over
    assign w_adv_inf = (r_req.adv_dist == r_inf);
    always_comb begin
        w_fin_status = ST_IGNORED;
        w_fin_we     = 1'b0;
        w_fin_add    = 1'b0;
        w_fin_addr   = r_hit_idx;
        w_fin_rec    = r_hit_rec;
        if (!r_hit) begin
            w_fin_addr = r_free_idx;
            w_fin_rec  = '{net: r_req.adv_net, prefix: r_req.adv_mask, metric: r_sum,
                           hop: r_req.sender, age: 8'd0};
            if (w_adv_inf) begin
                w_fin_status = ST_IGNORED;
            end else if (!r_free_ok) begin
                w_fin_status = ST_FULL;
            end else begin
                w_fin_status = ST_ADDED;
                w_fin_we     = 1'b1;
                w_fin_add    = 1'b1;
            end
        end else if (r_req.sender == r_hit_rec.hop) begin
            w_fin_we = 1'b1;
            if (w_adv_inf) begin
                w_fin_rec.metric = w_inf_db;
                w_fin_status     = ST_POISONED;
            end else begin
                w_fin_rec.metric = r_sum;
                w_fin_rec.age    = 8'd0;
                w_fin_status     = ST_UPDATED;
            end
        end else if (!w_adv_inf && (32'(r_hit_rec.metric) > 32'(r_sum))) begin
            w_fin_we         = 1'b1;
            w_fin_rec.metric = r_sum;
            w_fin_rec.age    = 8'd0;
            w_fin_rec.hop    = r_req.sender;
            w_fin_status     = ST_UPDATED;
        end
    end

    // Route memory ports
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_paddr;
        w_wdata = w_tick_rec;
        if (i_cmd == CMD_SCAN && r_pend && r_mode == SM_TICK && r_valid[r_paddr]) begin
            w_we = 1'b1;
        end else if (i_cmd == CMD_FINISH && r_mode == SM_ADV && w_fin_we) begin
            w_we    = 1'b1;
            w_waddr = w_fin_addr;
            w_wdata = w_fin_rec;
        end
        if (i_cmd == CMD_EVAL && r_req.action == ACT_READ) begin
            w_raddr = w_route_idx[AW-1:0];
        end else begin
            w_raddr = r_addr[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    // Configuration, interface state and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iface_count <= 3'd0;
            r_inf         <= 16'hFFFF;
            r_max         <= 16'd15;
            r_turns       <= 16'h0603;
            for (int g = 0; g < NUM_IFACES; g++) begin
                r_iface_reg[g]  <= '0;
                r_iface_dist[g] <= '0;
                r_iface_age[g]  <= 8'd0;
            end
            for (int r = 0; r < MAX_ROUTES; r++) begin
                r_valid[r] <= 1'b0;
            end
        end else begin
            // Take register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IFACE_COUNT: r_iface_count <= i_cfg_data[2:0];
                    CFG_INF_DIST:    r_inf         <= i_cfg_data[15:0];
                    CFG_MAX_DIST:    r_max         <= i_cfg_data[15:0];
                    CFG_TURNS:       r_turns       <= i_cfg_data[15:0];
                    default: begin
                        for (int g = 0; g < NUM_IFACES; g++) begin
                            if (i_cfg_index >= CFG_IFACE_0 && i_cfg_index <= CFG_IFACE_3 &&
                                    i_cfg_index - CFG_IFACE_0 == 3'(g)) begin
                                r_iface_reg[g]  <= i_cfg_data;
                                r_iface_dist[g] <= DIST_BITS'(32'(i_cfg_data[53:38]));
                                r_iface_age[g]  <= 8'd0;
                            end
                        end
                    end
                endcase
            end
            // First step of a request on the interfaces
            if (i_cmd == CMD_EVAL) begin
                if (r_req.action == ACT_ADV && w_snd_hit) begin
                    r_iface_age[w_snd_idx] <= 8'd0;
                    if (w_if_inf[w_snd_idx]) begin
                        r_iface_dist[w_snd_idx] <= w_if_start[w_snd_idx];
                    end
                end else if (r_req.action == ACT_TICK) begin
                    for (int g = 0; g < NUM_IFACES; g++) begin
                        if (3'(g) < w_used && r_iface_age[g] != w_stop_turns) begin
                            r_iface_age[g] <= r_iface_age[g] + 8'd1;
                            if (r_iface_age[g] + 8'd1 == w_inf_turns) begin
                                r_iface_dist[g] <= w_inf_db;
                            end
                        end
                    end
                end
            end
            // Route valid bits during the scan
            if (i_cmd == CMD_SCAN && r_pend) begin
                if (r_mode == SM_TICK && r_valid[r_paddr]) begin
                    r_valid[r_paddr] <= w_tick_keep;
                end else if (r_mode == SM_RECON && r_valid[r_paddr] && !r_hit &&
                        r_rd_data.net == r_key) begin
                    r_valid[r_paddr] <= 1'b0;
                end
            end
            if (i_cmd == CMD_FINISH && r_mode == SM_ADV && w_fin_add) begin
                r_valid[r_free_idx] <= 1'b1;
            end
        end
    end

    // Request capture and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_addr <= '0;
            r_hit  <= 1'b0;
            r_free_ok <= 1'b0;
        end else begin
            case (i_cmd)
                CMD_ACCEPT: begin
                    r_req     <= i_request;
                    r_addr    <= '0;
                    r_pend    <= 1'b0;
                    r_hit     <= 1'b0;
                    r_free_ok <= 1'b0;
                end
                CMD_EVAL: begin
                    r_sum   <= w_sum;
                    r_paddr <= '0;
                    for (int g = 0; g < NUM_IFACES; g++) begin
                        r_dead[g] <= (3'(g) < w_used) && (r_iface_age[g] != w_stop_turns) &&
                                     (r_iface_age[g] + 8'd1 == w_inf_turns);
                    end
                    if (r_req.action == ACT_READ) begin
                        r_mode     <= SM_READ;
                        r_pend     <= 1'b0;
                        r_addr     <= CW'(w_route_idx);
                        r_in_range <= (9'(r_req.read_index) >= 9'(NUM_IFACES)) &&
                                      (9'(w_route_idx) < 9'(MAX_ROUTES));
                    end else begin
                        r_addr <= CW'(1);
                        r_pend <= 1'b1;
                        if (r_req.action == ACT_TICK) begin
                            r_mode <= SM_TICK;
                        end else if (w_if_inf[w_snd_idx]) begin
                            r_mode <= SM_RECON;
                            r_key  <= w_if_net[w_snd_idx];
                        end else begin
                            r_mode <= SM_ADV;
                            r_key  <= r_req.adv_net;
                        end
                    end
                end
                CMD_SCAN: begin
                    if (r_mode != SM_READ) begin
                        r_pend  <= (r_addr < CW'(MAX_ROUTES));
                        r_paddr <= r_addr[AW-1:0];
                        if (r_addr < CW'(MAX_ROUTES)) begin
                            r_addr <= r_addr + CW'(1);
                        end
                    end
                    if (r_pend && r_valid[r_paddr] && !r_hit && r_rd_data.net == r_key &&
                            (r_mode == SM_ADV || r_mode == SM_RECON)) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_paddr;
                        r_hit_rec <= r_rd_data;
                    end
                    if (r_pend && !r_valid[r_paddr] && !r_free_ok) begin
                        r_free_ok  <= 1'b1;
                        r_free_idx <= r_paddr;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Form the result of a request that went through the scan
    always_comb begin
        w_fin_res = '0;
        case (r_mode)
            SM_RECON: w_fin_res.status = ST_RECONNECTED;
            SM_TICK:  w_fin_res.status = ST_TICKED;
            SM_ADV:   w_fin_res.status = w_fin_status;
            default: begin
                w_fin_res.status = ST_READ;
                if (r_in_range && r_valid[r_addr[AW-1:0]]) begin
                    w_fin_res.entry_valid = 1'b1;
                    w_fin_res.entry_net   = r_rd_data.net;
                    w_fin_res.entry_mask  = r_rd_data.prefix;
                    w_fin_res.entry_dist  = 16'(32'(r_rd_data.metric));
                    w_fin_res.entry_via   = r_rd_data.hop;
                end
            end
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stb <= 1'b0;
        end else begin
            r_stb <= (i_cmd == CMD_EVAL && w_no_scan) || (i_cmd == CMD_FINISH);
        end
        if (i_cmd == CMD_EVAL) begin
            r_res <= w_eval_res;
        end else if (i_cmd == CMD_FINISH) begin
            r_res <= w_fin_res;
        end
    end

    assign o_status.no_scan   = w_no_scan;
    assign o_status.scan_done = !r_pend;
    assign o_result_valid     = r_stb;
    assign o_result           = r_res;

endmodule

`default_nettype wire

// ===== hdl/distance_vector_route_table.sv =====
// Top level of the distance-vector route table.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------
//  request   | start / busy         | i_request (t_request)
//  result    | o_result_valid       | o_result (t_result)
//  config    | i_cfg_we             | i_cfg_index, i_cfg_data
//
// An advertisement that reaches the route table or a tick is settled by a scan of the
// route memory at one route per cycle. A read of an interface, an unknown sender or a
// locally held network is settled in the first step with no scan; a read of a route
// slot goes through the scan and finish steps. One request is worked on at a time.
// Reset is synchronous and clears control, configuration and valid bits; no clearing pass.
// The result shows for one cycle as busy drops; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none

module distance_vector_route_table #(
    parameter int NUM_IFACES = 4,
    parameter int MAX_ROUTES = 16,
    parameter int DIST_BITS  = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire dvrt_pkg::t_request i_request,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [53:0]        i_cfg_data,
    output logic                    o_result_valid,
    output dvrt_pkg::t_result       o_result
);
    import dvrt_pkg::*;

    t_cmd       w_cmd;
    t_dp_status w_status;

    // Sequence the request
    dvrt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    // Hold table state and form results
    dvrt_datapath #(
        .NUM_IFACES (NUM_IFACES),
        .MAX_ROUTES (MAX_ROUTES),
        .DIST_BITS  (DIST_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_request      (i_request),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_status       (w_status),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

`default_nettype wire

// ===== hdl/dvrt_checker.sv =====
// Port-level checks for the route table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dvrt_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_result_valid,
    input wire dvrt_pkg::t_result  o_result
);
    import dvrt_pkg::*;

    // An accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // Every finished request gives a result
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("busy dropped without a result");

    // A result only follows work in progress
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without a request");

    // Only a read carries entry fields
    a_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status != ST_READ) |->
            (o_result.entry_valid == 1'b0 && o_result.entry_direct == 1'b0 &&
             o_result.entry_net == 32'd0 && o_result.entry_dist == 16'd0 &&
             o_result.entry_via == 32'd0))
        else $error("entry fields set on a non-read result");

    // Reset leaves the block idle
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_result_valid))
        else $error("block not idle after reset");

endmodule

bind distance_vector_route_table dvrt_checker u_dvrt_checker (.*);

`default_nettype wire
